FILE: rtl/core/als_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// als_pkg
// Shared constants, request codes and the command and status bundles that
// pass between the line stepper controller and its datapath.
// ----------------------------------------------------------------------------
package als_pkg;

    // Default sizes handed to the top level parameters.
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;

    // Pixel intensity.
    localparam int               LEVEL_BITS = 8;
    localparam logic [LEVEL_BITS-1:0] LEVEL_FULL = 8'hFF;

    // Request codes carried on op.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // latch endpoints and set up a new line
        logic div_run;  // run one iteration of the slope division
        logic advance;  // emit the current pixel and move one step
    } als_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic straight;    // endpoints on the input form a straight line
        logic div_done;    // this is the last division iteration
        logic final_step;  // the current pixel is the last of the line
    } als_sts_t;

endpackage

FILE: rtl/core/als_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// als_ctrl
// Controller for the line stepper: sequences load, slope division and the
// walk, and owns the request handshake and the result valid flag.
// ----------------------------------------------------------------------------
module als_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_valid,
    input  logic               op,
    output logic               step_stall,
    output logic               pixel_valid,
    input  logic               pixel_stall,
    input  als_pkg::als_sts_t  sts,
    output als_pkg::als_cmd_t  cmd
);
    import als_pkg::*;

    typedef enum logic [1:0] {
        ST_NOLINE,
        ST_DIVIDE,
        ST_WALK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   pixel_valid_reg;
    logic   pixel_valid_next;
    logic   accept;

    // Requests wait while the divider runs or a result is held up downstream.
    assign step_stall  = (state_reg == ST_DIVIDE) || (pixel_valid_reg && pixel_stall);
    assign accept      = step_valid && !step_stall;
    assign pixel_valid = pixel_valid_reg;

    // Next state and commands.
    always_comb
    begin
        cmd              = '0;
        state_next       = state_reg;
        pixel_valid_next = pixel_valid_reg && pixel_stall;
        if (accept && (op == OP_LOAD))
        begin
            cmd.load   = 1'b1;
            state_next = sts.straight ? ST_WALK : ST_DIVIDE;
        end
        else
        begin
            case (state_reg)
                ST_DIVIDE:
                begin
                    cmd.div_run = 1'b1;
                    if (sts.div_done)
                    begin
                        state_next = ST_WALK;
                    end
                end
                ST_WALK:
                begin
                    if (accept)
                    begin
                        cmd.advance      = 1'b1;
                        pixel_valid_next = 1'b1;
                        if (sts.final_step)
                        begin
                            state_next = ST_NOLINE;
                        end
                    end
                end
                ST_NOLINE:
                begin
                    // A step with no line loaded is taken and dropped.
                    state_next = ST_NOLINE;
                end
                default:
                begin
                    state_next = ST_NOLINE;
                end
            endcase
        end
    end

    // State and registered valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_NOLINE;
            pixel_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pixel_valid_reg <= pixel_valid_next;
        end
    end

endmodule

FILE: rtl/core/als_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// als_dp
// Datapath for the line stepper: endpoint setup, a restoring divider for the
// slope, the error accumulator and position counters, and result registers.
// ----------------------------------------------------------------------------
module als_dp
#(
    parameter int COORD_BITS = als_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = als_pkg::FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  als_pkg::als_cmd_t             cmd,
    output als_pkg::als_sts_t             sts,
    input  logic [COORD_BITS-1:0]         x_start,
    input  logic [COORD_BITS-1:0]         y_start,
    input  logic [COORD_BITS-1:0]         x_end,
    input  logic [COORD_BITS-1:0]         y_end,
    output logic [COORD_BITS-1:0]         main_x,
    output logic [COORD_BITS-1:0]         main_y,
    output logic [als_pkg::LEVEL_BITS-1:0] main_level,
    output logic signed [COORD_BITS+1:0]  side_x,
    output logic signed [COORD_BITS+1:0]  side_y,
    output logic [als_pkg::LEVEL_BITS-1:0] side_level,
    output logic                          side_valid,
    output logic                          last
);
    import als_pkg::*;

    localparam int SIDE_BITS  = COORD_BITS + 2;
    localparam int ERR_BITS   = FRAC_BITS + LEVEL_BITS;
    localparam int SLOPE_BITS = ERR_BITS + 1;
    localparam int CNT_BITS   = $clog2(SLOPE_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(SLOPE_BITS - 1);
    localparam logic [ERR_BITS-1:0] ERR_INIT = {LEVEL_FULL, {FRAC_BITS{1'b0}}};

    // Line state.
    logic [COORD_BITS-1:0] pos_x_reg, pos_y_reg, steps_left_reg;
    logic [ERR_BITS-1:0]   error_acc_reg;
    logic [SLOPE_BITS-1:0] slope_step_reg;
    logic                  major_is_x_reg, minor_negative_reg, straight_reg;

    // Divider state.
    logic [COORD_BITS:0]   rem_reg;
    logic [CNT_BITS-1:0]   cnt_reg;

    // Result registers.
    logic [COORD_BITS-1:0] main_x_reg, main_y_reg;
    logic [LEVEL_BITS-1:0] main_level_reg, side_level_reg;
    logic [SIDE_BITS-1:0]  side_x_reg, side_y_reg;
    logic                  side_valid_reg, last_reg;

    // Setup signals.
    logic                  is_vert, is_straight, a_low;
    logic [COORD_BITS-1:0] lx, hx, ly, hy, span_x, span_y, maj, mnr;
    logic                  up, x_major;
    logic [COORD_BITS-1:0] init_x, init_y, init_steps;
    logic                  init_major_x, init_neg;

    // Walk signals.
    logic [ERR_BITS:0]     err_diff;
    logic                  err_wrap;
    logic [COORD_BITS-1:0] minor_delta;
    logic [SIDE_BITS-1:0]  side_delta;
    logic [COORD_BITS-1:0] step_x, step_y;
    logic [LEVEL_BITS-1:0] cur_level;

    // Divider signals.
    logic                  div_ge;
    logic [COORD_BITS:0]   div_rem;

    // Endpoint setup: classify the line and pick start point and spans.
    always_comb
    begin
        is_vert     = (x_start == x_end);
        is_straight = is_vert || (y_start == y_end);
        a_low       = (x_start < x_end);
        lx          = a_low ? x_start : x_end;
        hx          = a_low ? x_end : x_start;
        ly          = a_low ? y_start : y_end;
        hy          = a_low ? y_end : y_start;
        span_x      = hx - lx;
        up          = (hy > ly);
        span_y      = up ? (hy - ly) : (ly - hy);
        x_major     = (span_x > span_y);
        maj         = x_major ? span_x : span_y;
        mnr         = x_major ? span_y : span_x;
        if (is_straight)
        begin
            init_neg = 1'b0;
            if (is_vert)
            begin
                init_major_x = 1'b0;
                init_x       = x_start;
                init_y       = (y_start < y_end) ? y_start : y_end;
                init_steps   = (y_start < y_end) ? (y_end - y_start) : (y_start - y_end);
            end
            else
            begin
                init_major_x = 1'b1;
                init_y       = y_start;
                init_x       = lx;
                init_steps   = span_x;
            end
        end
        else
        begin
            init_major_x = x_major;
            init_steps   = maj;
            if (x_major || up)
            begin
                init_x   = lx;
                init_y   = ly;
                init_neg = !up;
            end
            else
            begin
                init_x   = hx;
                init_y   = hy;
                init_neg = 1'b1;
            end
        end
    end

    // One restoring division iteration; the divisor is the major span.
    assign div_ge  = (rem_reg >= {1'b0, steps_left_reg});
    assign div_rem = div_ge ? (rem_reg - {1'b0, steps_left_reg}) : rem_reg;

    // Error update: the low bits of the difference already hold the wrapped value.
    assign err_diff    = {1'b0, error_acc_reg} - slope_step_reg;
    assign err_wrap    = err_diff[ERR_BITS];
    assign cur_level   = error_acc_reg[ERR_BITS-1:FRAC_BITS];
    assign minor_delta = minor_negative_reg ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
    assign side_delta  = minor_negative_reg ? {SIDE_BITS{1'b1}} : SIDE_BITS'(1);

    // Next position after one step.
    always_comb
    begin
        step_x = pos_x_reg;
        step_y = pos_y_reg;
        if (major_is_x_reg)
        begin
            step_x = pos_x_reg + COORD_BITS'(1);
            if (!straight_reg && err_wrap)
            begin
                step_y = pos_y_reg + minor_delta;
            end
        end
        else
        begin
            step_y = pos_y_reg + COORD_BITS'(1);
            if (!straight_reg && err_wrap)
            begin
                step_x = pos_x_reg + minor_delta;
            end
        end
    end

    // Line state and divider.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg          <= '0;
            pos_y_reg          <= '0;
            steps_left_reg     <= '0;
            error_acc_reg      <= ERR_INIT;
            slope_step_reg     <= '0;
            major_is_x_reg     <= 1'b0;
            minor_negative_reg <= 1'b0;
            straight_reg       <= 1'b0;
            rem_reg            <= '0;
            cnt_reg            <= '0;
        end
        else if (cmd.load)
        begin
            pos_x_reg          <= init_x;
            pos_y_reg          <= init_y;
            steps_left_reg     <= init_steps;
            error_acc_reg      <= ERR_INIT;
            slope_step_reg     <= '0;
            major_is_x_reg     <= init_major_x;
            minor_negative_reg <= init_neg;
            straight_reg       <= is_straight;
            rem_reg            <= {1'b0, mnr};
            cnt_reg            <= '0;
        end
        else if (cmd.div_run)
        begin
            slope_step_reg <= {slope_step_reg[SLOPE_BITS-2:0], div_ge};
            rem_reg        <= {div_rem[COORD_BITS-1:0], 1'b0};
            cnt_reg        <= cnt_reg + CNT_BITS'(1);
        end
        else if (cmd.advance)
        begin
            pos_x_reg <= step_x;
            pos_y_reg <= step_y;
            if (!straight_reg)
            begin
                error_acc_reg <= err_diff[ERR_BITS-1:0];
            end
            if (steps_left_reg != '0)
            begin
                steps_left_reg <= steps_left_reg - COORD_BITS'(1);
            end
        end
    end

    // Result registers, loaded on each emitted pixel.
    always_ff @(posedge clk)
    begin
        if (cmd.advance)
        begin
            main_x_reg <= pos_x_reg;
            main_y_reg <= pos_y_reg;
            last_reg   <= (steps_left_reg == '0);
            if (straight_reg)
            begin
                main_level_reg <= LEVEL_FULL;
                side_level_reg <= '0;
                side_x_reg     <= '0;
                side_y_reg     <= '0;
                side_valid_reg <= 1'b0;
            end
            else
            begin
                main_level_reg <= cur_level;
                side_level_reg <= LEVEL_FULL - cur_level;
                side_valid_reg <= 1'b1;
                if (major_is_x_reg)
                begin
                    side_x_reg <= {2'b00, pos_x_reg};
                    side_y_reg <= {2'b00, pos_y_reg} + side_delta;
                end
                else
                begin
                    side_x_reg <= {2'b00, pos_x_reg} + side_delta;
                    side_y_reg <= {2'b00, pos_y_reg};
                end
            end
        end
    end

    // Status to the controller.
    assign sts.straight   = is_straight;
    assign sts.div_done   = (cnt_reg == CNT_LAST);
    assign sts.final_step = (steps_left_reg == '0);

    assign main_x     = main_x_reg;
    assign main_y     = main_y_reg;
    assign main_level = main_level_reg;
    assign side_x     = $signed(side_x_reg);
    assign side_y     = $signed(side_y_reg);
    assign side_level = side_level_reg;
    assign side_valid = side_valid_reg;
    assign last       = last_reg;

endmodule

FILE: rtl/core/antialiased_line_stepper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// antialiased_line_stepper
// Antialiased line rasterizer: one request loads a line, each later step
// request returns one pixel pair with complementary intensities.
// ----------------------------------------------------------------------------
// A load request (op = 0) returns no pixel. For a horizontal, vertical or
// single-point line the block is ready for steps on the next cycle; for any
// other line it then runs a restoring slope division, one quotient bit per
// cycle, with step_stall high. Each step request (op = 1) then returns one
// pixel per cycle while pixel_stall is low; the result sits in an output
// register, so a new request is taken in the same cycle that the previous
// result leaves. A line from a to b gives max(|dx|, |dy|) + 1 pixels, the
// last with last = 1. A step with no line loaded is taken and returns
// nothing. A load is taken whenever step_stall is low, also during a walk,
// and replaces the line in progress.
module antialiased_line_stepper
#(
    parameter int COORD_BITS = als_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = als_pkg::FRAC_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step_valid,
    output logic                           step_stall,
    input  logic                           op,
    input  logic [COORD_BITS-1:0]          x_start,
    input  logic [COORD_BITS-1:0]          y_start,
    input  logic [COORD_BITS-1:0]          x_end,
    input  logic [COORD_BITS-1:0]          y_end,
    output logic                           pixel_valid,
    input  logic                           pixel_stall,
    output logic [COORD_BITS-1:0]          main_x,
    output logic [COORD_BITS-1:0]          main_y,
    output logic [als_pkg::LEVEL_BITS-1:0] main_level,
    output logic signed [COORD_BITS+1:0]   side_x,
    output logic signed [COORD_BITS+1:0]   side_y,
    output logic [als_pkg::LEVEL_BITS-1:0] side_level,
    output logic                           side_valid,
    output logic                           last
);
    import als_pkg::*;

    als_cmd_t cmd;
    als_sts_t sts;

    // Sequencing and handshake.
    als_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_valid  (step_valid),
        .op          (op),
        .step_stall  (step_stall),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .sts         (sts),
        .cmd         (cmd)
    );

    // Setup, division, walk and result registers.
    als_dp
    #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .x_start    (x_start),
        .y_start    (y_start),
        .x_end      (x_end),
        .y_end      (y_end),
        .main_x     (main_x),
        .main_y     (main_y),
        .main_level (main_level),
        .side_x     (side_x),
        .side_y     (side_y),
        .side_level (side_level),
        .side_valid (side_valid),
        .last       (last)
    );

endmodule

FILE: verif/tb_antialiased_line_stepper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_antialiased_line_stepper
// Self-checking bench for the antialiased line stepper. A directed list
// covers straight lines, the single point, the exact diagonal, side pixels
// that fall off the coordinate range, and a load in the middle of a walk.
// Random line sequences follow. Every accepted request goes through a local
// line walker, and each pixel that leaves the block is checked field by
// field against the oldest predicted pixel.
// ----------------------------------------------------------------------------
module tb_antialiased_line_stepper;

    import als_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int LB = LEVEL_BITS;
    localparam int COORD_MAX = (1 << CB) - 1;

    localparam int CLK_PERIOD  = 12;
    localparam int RESET_CYCLES = 7;
    localparam int ITEM_TARGET = 2000;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_AFTER  = 600;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 40;

    localparam longint ERR_START = longint'(255) << FB;
    localparam longint ERR_WRAP  = longint'(256) << FB;

    typedef logic [CB-1:0]        coord_t;
    typedef logic signed [CB+1:0] side_t;
    typedef logic [LB-1:0]        level_t;

    typedef enum logic [1:0] {LINE_IDLE, LINE_STRAIGHT, LINE_GENERAL} line_mode_t;
    typedef enum logic [1:0] {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

    typedef struct {
        logic   op;
        coord_t xs;
        coord_t ys;
        coord_t xe;
        coord_t ye;
        bit     drain;
    } line_req_t;

    typedef struct packed {
        coord_t main_x;
        coord_t main_y;
        level_t main_level;
        side_t  side_x;
        side_t  side_y;
        level_t side_level;
        logic   side_valid;
        logic   is_last;
    } pixel_t;

    // Clock and reset.
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Block ports.
    logic         step_valid  = 1'b0;
    logic         step_stall;
    logic         op          = OP_LOAD;
    coord_t       x_start     = '0;
    coord_t       y_start     = '0;
    coord_t       x_end       = '0;
    coord_t       y_end       = '0;
    logic         pixel_valid;
    logic         pixel_stall = 1'b0;
    coord_t       main_x;
    coord_t       main_y;
    level_t       main_level;
    side_t        side_x;
    side_t        side_y;
    level_t       side_level;
    logic         side_valid;
    logic         last;

    antialiased_line_stepper dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_valid  (step_valid),
        .step_stall  (step_stall),
        .op          (op),
        .x_start     (x_start),
        .y_start     (y_start),
        .x_end       (x_end),
        .y_end       (y_end),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .main_x      (main_x),
        .main_y      (main_y),
        .main_level  (main_level),
        .side_x      (side_x),
        .side_y      (side_y),
        .side_level  (side_level),
        .side_valid  (side_valid),
        .last        (last)
    );

    // Requests waiting to be sent and pixels waiting to come out.
    line_req_t pending_reqs[$];
    pixel_t    expected_pixels[$];
    int        accepted_reqs  = 0;
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    bit        drain_next     = 1'b0;

    // Local copy of the line walker state.
    coord_t     line_x;
    coord_t     line_y;
    coord_t     line_left;
    longint     line_err;
    longint     line_slope;
    logic       line_major_x;
    logic       line_minor_neg;
    line_mode_t line_mode;

    // Set up a new line from two endpoints, as a load request does.
    function automatic void setup_line(input coord_t ax, input coord_t ay,
                                       input coord_t bx, input coord_t by);
        coord_t lo_x;
        coord_t hi_x;
        coord_t lo_y;
        coord_t hi_y;
        int     span_x;
        int     span_y;
        int     major_len;
        int     minor_len;
        line_err       = ERR_START;
        line_slope     = 0;
        line_minor_neg = 1'b0;
        if (ax == bx || ay == by)
        begin
            line_mode = LINE_STRAIGHT;
            if (ax == bx)
            begin
                line_major_x = 1'b0;
                line_x       = ax;
                line_y       = (ay < by) ? ay : by;
                line_left    = (ay < by) ? by - ay : ay - by;
            end
            else
            begin
                line_major_x = 1'b1;
                line_y       = ay;
                line_x       = (ax < bx) ? ax : bx;
                line_left    = (ax < bx) ? bx - ax : ax - bx;
            end
            return;
        end
        // Order the endpoints by x; x-major lines start from the one with the lower x.
        lo_x   = (ax < bx) ? ax : bx;
        hi_x   = (ax < bx) ? bx : ax;
        lo_y   = (ax < bx) ? ay : by;
        hi_y   = (ax < bx) ? by : ay;
        span_x = int'(hi_x) - int'(lo_x);
        span_y = (hi_y > lo_y) ? int'(hi_y) - int'(lo_y) : int'(lo_y) - int'(hi_y);
        line_mode = LINE_GENERAL;
        if (span_x > span_y)
        begin
            line_major_x   = 1'b1;
            major_len      = span_x;
            minor_len      = span_y;
            line_x         = lo_x;
            line_y         = lo_y;
            line_minor_neg = (hi_y > lo_y) ? 1'b0 : 1'b1;
        end
        else
        begin
            // Y-major lines start from the endpoint with the lower y.
            line_major_x = 1'b0;
            major_len    = span_y;
            minor_len    = span_x;
            if (hi_y > lo_y)
            begin
                line_x         = lo_x;
                line_y         = lo_y;
                line_minor_neg = 1'b0;
            end
            else
            begin
                line_x         = hi_x;
                line_y         = hi_y;
                line_minor_neg = 1'b1;
            end
        end
        line_left  = coord_t'(major_len);
        line_slope = (longint'(minor_len) << (FB + 8)) / longint'(major_len);
    endfunction

    // Advance the walk by one step; returns 1 when a pixel comes out.
    function automatic bit walk_line(output pixel_t px);
        bit     fin;
        longint lvl;
        int     dir;
        px = '0;
        if (line_mode == LINE_IDLE)
            return 1'b0;
        fin        = (line_left == 0);
        px.main_x  = line_x;
        px.main_y  = line_y;
        px.is_last = fin;
        if (line_mode == LINE_STRAIGHT)
        begin
            px.main_level = LEVEL_FULL;
            if (line_major_x)
                line_x = line_x + 1'b1;
            else
                line_y = line_y + 1'b1;
        end
        else
        begin
            lvl = (line_err >= 0) ? ((line_err >> FB) & 255) : 0;
            dir = line_minor_neg ? -1 : 1;
            px.main_level = level_t'(lvl);
            px.side_level = LEVEL_FULL - level_t'(lvl);
            px.side_valid = 1'b1;
            if (line_major_x)
            begin
                px.side_x = side_t'(int'(line_x));
                px.side_y = side_t'(int'(line_y) + dir);
                line_x    = line_x + 1'b1;
            end
            else
            begin
                px.side_x = side_t'(int'(line_x) + dir);
                px.side_y = side_t'(int'(line_y));
                line_y    = line_y + 1'b1;
            end
            // A negative error means a move along the minor axis.
            line_err = line_err - line_slope;
            if (line_err < 0)
            begin
                line_err = line_err + ERR_WRAP;
                if (line_major_x)
                    line_y = line_y + coord_t'(dir);
                else
                    line_x = line_x + coord_t'(dir);
            end
        end
        if (fin)
            line_mode = LINE_IDLE;
        else
            line_left = line_left - 1'b1;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS)
            $display("ERROR at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [CB+1:0] got,
                               input logic [CB+1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task automatic push_req(input logic req_op, input int xs, input int ys,
                            input int xe, input int ye);
        line_req_t r;
        r.op    = req_op;
        r.xs    = coord_t'(xs);
        r.ys    = coord_t'(ys);
        r.xe    = coord_t'(xe);
        r.ye    = coord_t'(ye);
        r.drain = drain_next;
        drain_next = 1'b0;
        pending_reqs.push_back(r);
    endtask

    // Step requests carry random endpoints, which the block must ignore.
    task automatic push_steps(input int n);
        repeat (n)
            push_req(OP_STEP, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                     $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
    endtask

    function automatic int near_coord(input int base, input int span);
        int v;
        v = base + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return v;
    endfunction

    // Request driver: bursts of random length with random gaps between them.
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        line_req_t cur_req;
        pixel_t    px;
        logic      nxt_valid;
        int        burst_left;
        int        gap_left;
        if (!rst_n)
        begin
            step_valid <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            nxt_valid = step_valid;
            if (step_valid && !step_stall)
            begin
                if (cur_req.op == OP_LOAD)
                    setup_line(cur_req.xs, cur_req.ys, cur_req.xe, cur_req.ye);
                else if (walk_line(px))
                    expected_pixels.push_back(px);
                accepted_reqs++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_reqs.size() != 0 &&
                         !(pending_reqs[0].drain && expected_pixels.size() != 0))
                begin
                    cur_req = pending_reqs.pop_front();
                    op      <= cur_req.op;
                    x_start <= cur_req.xs;
                    y_start <= cur_req.ys;
                    x_end   <= cur_req.xe;
                    y_end   <= cur_req.ye;
                    nxt_valid = 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
            step_valid <= nxt_valid;
        end
    end

    // Pixel receiver: changing stall patterns, plus one long hold-off.
    always @(posedge clk or negedge rst_n)
    begin : receive_proc
        rx_mode_t rx_mode;
        int       mode_left;
        int       hold_left;
        bit       hold_done;
        logic     stall_now;
        if (!rst_n)
        begin
            pixel_stall <= 1'b0;
            rx_mode   = RX_FLOW;
            mode_left = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                stall_now = 1'b1;
            end
            else if (!hold_done && accepted_reqs >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                stall_now = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                else
                    mode_left--;
                case (rx_mode)
                    RX_FLOW:  stall_now = 1'b0;
                    RX_LIGHT: stall_now = ($urandom_range(0, 3) == 0);
                    RX_HEAVY: stall_now = ($urandom_range(0, 3) != 0);
                    default:  stall_now = !pixel_stall;
                endcase
            end
            pixel_stall <= stall_now;
        end
    end

    // Pixel checker.
    always @(posedge clk)
    begin : watch_proc
        pixel_t want;
        if (rst_n && pixel_valid && !pixel_stall)
        begin
            if (expected_pixels.size() == 0)
                report_mismatch($sformatf("pixel (%0d,%0d) with none expected",
                                          main_x, main_y));
            else
            begin
                want = expected_pixels.pop_front();
                check_field("main_x", main_x, want.main_x);
                check_field("main_y", main_y, want.main_y);
                check_field("main_level", main_level, want.main_level);
                check_field("side_x", side_x, want.side_x);
                check_field("side_y", side_y, want.side_y);
                check_field("side_level", side_level, want.side_level);
                check_field("side_valid", side_valid, want.side_valid);
                check_field("last", last, want.is_last);
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial
    begin : stim_proc
        int  counted;
        int  pick;
        int  shape;
        int  span;
        int  ax;
        int  ay;
        int  bx;
        int  by;
        int  dd;
        int  line_len;
        int  n_steps;
        bit  drained_a;
        bit  drained_b;

        line_mode = LINE_IDLE;
        line_x = '0;
        line_y = '0;
        line_left = '0;
        line_err = ERR_START;
        line_slope = 0;
        line_major_x = 1'b0;
        line_minor_neg = 1'b0;

        // Step with no line loaded, then a single point.
        push_req(OP_STEP, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        push_req(OP_LOAD, 0, 0, 0, 0);
        push_steps(2);
        // Horizontal line given right to left at the top of the range.
        push_req(OP_LOAD, COORD_MAX, 7, COORD_MAX - 3, 7);
        push_steps(4);
        // Vertical line.
        push_req(OP_LOAD, 3, 0, 3, 1);
        push_steps(2);
        // Exact diagonal across the whole range, dropped by a new load.
        push_req(OP_LOAD, COORD_MAX, COORD_MAX, 0, 0);
        push_steps(2);
        // Y-major line walking toward x = 0, so the side x reaches -1.
        push_req(OP_LOAD, 1, 0, 0, 2);
        push_steps(3);
        // X-major line near the top row, so the side y reaches 4096.
        push_req(OP_LOAD, 0, COORD_MAX - 1, 2, COORD_MAX);
        push_steps(3);

        // Random line sequences with a little noise between them.
        counted   = 0;
        drained_a = 1'b0;
        drained_b = 1'b0;
        while (counted < ITEM_TARGET)
        begin
            if (!drained_a && counted >= 700)
            begin
                drained_a  = 1'b1;
                drain_next = 1'b1;
            end
            if (!drained_b && counted >= 1500)
            begin
                drained_b  = 1'b1;
                drain_next = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                push_req(logic'($urandom_range(0, 1)), $urandom_range(0, COORD_MAX),
                         $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                         $urandom_range(0, COORD_MAX));
                counted++;
            end
            else
            begin
                ax    = $urandom_range(0, COORD_MAX);
                ay    = $urandom_range(0, COORD_MAX);
                span  = (pick < 70) ? 15 : ((pick < 92) ? 80 : COORD_MAX);
                shape = $urandom_range(0, 5);
                case (shape)
                    0:
                    begin
                        bx = ax;
                        by = near_coord(ay, span);
                    end
                    1:
                    begin
                        bx = near_coord(ax, span);
                        by = ay;
                    end
                    2:
                    begin
                        dd = $urandom_range(0, (span < 2047) ? span : 2047);
                        bx = (ax < 2048) ? ax + dd : ax - dd;
                        by = (ay < 2048) ? ay + dd : ay - dd;
                    end
                    default:
                    begin
                        bx = near_coord(ax, span);
                        by = near_coord(ay, span);
                    end
                endcase
                line_len = (ax > bx) ? ax - bx : bx - ax;
                dd       = (ay > by) ? ay - by : by - ay;
                line_len = ((dd > line_len) ? dd : line_len) + 1;
                n_steps  = line_len;
                pick     = $urandom_range(0, 9);
                if (pick == 0)
                    n_steps = $urandom_range(0, line_len);
                else if (pick == 1)
                    n_steps = line_len + $urandom_range(1, 2);
                if (n_steps > 120)
                    n_steps = $urandom_range(1, 40);
                push_req(OP_LOAD, ax, ay, bx, by);
                push_steps(n_steps);
                counted += 1 + ((n_steps < line_len) ? n_steps : line_len);
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every request to go in and every pixel to come out.
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || step_valid);
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/als_pkg.sv
rtl/core/als_ctrl.sv
rtl/core/als_dp.sv
rtl/core/antialiased_line_stepper.sv
verif/tb_antialiased_line_stepper.sv
